FILE: hdl/lfss_pkg.sv
`timescale 1ns / 1ps

package lfss_pkg;

    // Store geometry
    localparam int PIXELS_PER_GROUP = 48;
    localparam int MAX_GROUPS_DEF   = 2;
    localparam int CHIP_STEP        = 8 * 3;

    // Address field width in a command, enough for the largest store
    localparam int CMD_AW = 8;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Input item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_BYTE  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // Back-end operations
    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_BYTE  = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_REPLY = 3'd4;

    // Byte selection for a frame byte
    localparam logic [2:0] SEL_HI = 3'd0;
    localparam logic [2:0] SEL_LO = 3'd1;
    localparam logic [2:0] SEL_P0 = 3'd2;
    localparam logic [2:0] SEL_P1 = 3'd3;
    localparam logic [2:0] SEL_P2 = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_DRIVER_TYPE = 2'd0;
    localparam logic [1:0] REG_GROUP_COUNT = 2'd1;
    localparam logic [1:0] REG_CHAIN_REMAP = 2'd2;
    localparam logic [1:0] REG_CURVE_MODE  = 2'd3;

    typedef struct packed {
        logic       driver_type;
        logic [1:0] group_count;
        logic       chain_remap;
        logic       curve_mode;
    } cfg_t;

    typedef struct packed {
        logic [2:0]        op;
        logic [2:0]        byte_sel;
        logic              need_b;
        logic              eof;
        logic              bad;
        logic [CMD_AW-1:0] addr_a;
        logic [CMD_AW-1:0] addr_b;
        logic [7:0]        value;
    } cmd_t;

    // Chip segment of a logical index: number of 24-pixel steps below it
    function automatic logic [2:0] chip_seg(input logic [6:0] idx);
        logic [2:0] seg;
        seg = '0;
        for (int k = 1; k <= 5; k++)
        begin
            if (idx >= 7'(k * CHIP_STEP))
            begin
                seg = seg + 3'd1;
            end
        end
        return seg;
    endfunction

endpackage

FILE: hdl/lfss_ram.sv
`timescale 1ns / 1ps

module lfss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 96
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/lfss_front.sv
`timescale 1ns / 1ps

module lfss_front #(
    parameter int MAX_GROUPS = lfss_pkg::MAX_GROUPS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lfss_pkg::cfg_t cfg,
    input  logic          start,
    input  logic          full,
    input  logic [1:0]    kind,
    input  logic [6:0]    pixel_index,
    input  logic [7:0]    pixel_value,
    output logic          push,
    output lfss_pkg::cmd_t push_cmd
);

    localparam int STORE_DEPTH = MAX_GROUPS * lfss_pkg::PIXELS_PER_GROUP;
    localparam int PIX_W       = $clog2(STORE_DEPTH + 1);
    localparam int LEN_W       = $clog2(2 * STORE_DEPTH + 1);
    localparam int LEN16_STEP  = 2 * lfss_pkg::PIXELS_PER_GROUP;
    localparam int LEN12_STEP  = lfss_pkg::PIXELS_PER_GROUP / 2 * 3;
    localparam int AW          = lfss_pkg::CMD_AW;

    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0] div3_reg, div3_next;
    logic [1:0]       mod3_reg, mod3_next;

    logic [1:0]       groups;
    logic [PIX_W-1:0] pix_count;
    logic [LEN_W-1:0] frame_len;
    logic             bad;
    logic [2:0]       seg;
    logic [6:0]       seg_rem;
    logic [2:0]       stops;
    logic [AW-1:0]    phys;
    logic             stale;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] div3;
    logic [1:0]       mod3;
    logic             last;
    logic [AW-1:0]    addr16;
    logic [AW-1:0]    addr_pa;
    logic [AW-1:0]    addr_pb;

    assign push = start && !full;

    // Decode chain size and frame length
    always_comb
    begin
        if (cfg.group_count == 2'd0)
        begin
            groups = 2'd1;
        end
        else if (int'(cfg.group_count) > MAX_GROUPS)
        begin
            groups = 2'(MAX_GROUPS);
        end
        else
        begin
            groups = cfg.group_count;
        end
        pix_count = PIX_W'(int'(groups) * lfss_pkg::PIXELS_PER_GROUP);
        frame_len = cfg.driver_type ? LEN_W'(int'(groups) * LEN12_STEP)
                                    : LEN_W'(int'(groups) * LEN16_STEP);
        bad       = int'(pixel_index) >= int'(pix_count);
    end

    // Map logical index to physical store location
    always_comb
    begin
        seg     = lfss_pkg::chip_seg(pixel_index);
        seg_rem = pixel_index - 7'(lfss_pkg::CHIP_STEP * int'(seg));
        stops   = 3'(2 * int'(groups) - 1);
        if (!cfg.chain_remap)
        begin
            phys = AW'(pixel_index);
        end
        else if (int'(pixel_index) < int'(groups) * lfss_pkg::CHIP_STEP)
        begin
            phys = AW'(int'(pixel_index) + lfss_pkg::CHIP_STEP * int'(seg));
        end
        else
        begin
            phys = AW'(int'(3'(stops - seg)) * (2 * lfss_pkg::CHIP_STEP)
                       + lfss_pkg::CHIP_STEP + int'(seg_rem));
        end
    end

    // Work out the frame byte position and its store addresses
    always_comb
    begin
        stale   = pos_reg >= frame_len;
        pos     = stale ? '0 : pos_reg;
        div3    = stale ? '0 : div3_reg;
        mod3    = stale ? 2'd0 : mod3_reg;
        last    = int'(pos) + 1 >= int'(frame_len);
        addr16  = AW'(int'(pix_count) - 1 - int'(pos >> 1));
        addr_pa = AW'(int'(pix_count) - 1 - 2 * int'(div3));
        addr_pb = AW'(int'(pix_count) - 2 - 2 * int'(div3));
    end

    // Build the command and advance the frame position
    always_comb
    begin
        pos_next          = pos_reg;
        div3_next         = div3_reg;
        mod3_next         = mod3_reg;
        push_cmd          = '0;
        push_cmd.value    = pixel_value;
        case (kind)
            lfss_pkg::KIND_WRITE, lfss_pkg::KIND_READ:
            begin
                if (bad)
                begin
                    push_cmd.op  = lfss_pkg::OP_REPLY;
                    push_cmd.bad = 1'b1;
                end
                else
                begin
                    push_cmd.addr_a = phys;
                    if (kind == lfss_pkg::KIND_WRITE)
                    begin
                        push_cmd.op = lfss_pkg::OP_WRITE;
                        pos_next    = '0;
                        div3_next   = '0;
                        mod3_next   = 2'd0;
                    end
                    else
                    begin
                        push_cmd.op = lfss_pkg::OP_READ;
                    end
                end
            end
            lfss_pkg::KIND_BYTE:
            begin
                push_cmd.op  = lfss_pkg::OP_BYTE;
                push_cmd.eof = last;
                if (!cfg.driver_type)
                begin
                    push_cmd.addr_a   = addr16;
                    push_cmd.byte_sel = pos[0] ? lfss_pkg::SEL_LO : lfss_pkg::SEL_HI;
                end
                else
                begin
                    case (mod3)
                        2'd0:
                        begin
                            push_cmd.addr_a   = addr_pa;
                            push_cmd.byte_sel = lfss_pkg::SEL_P0;
                        end
                        2'd1:
                        begin
                            push_cmd.addr_a   = addr_pa;
                            push_cmd.addr_b   = addr_pb;
                            push_cmd.need_b   = 1'b1;
                            push_cmd.byte_sel = lfss_pkg::SEL_P1;
                        end
                        default:
                        begin
                            push_cmd.addr_a   = addr_pb;
                            push_cmd.byte_sel = lfss_pkg::SEL_P2;
                        end
                    endcase
                end
                if (last)
                begin
                    pos_next  = '0;
                    div3_next = '0;
                    mod3_next = 2'd0;
                end
                else
                begin
                    pos_next = pos + LEN_W'(1);
                    if (mod3 == 2'd2)
                    begin
                        mod3_next = 2'd0;
                        div3_next = div3 + LEN_W'(1);
                    end
                    else
                    begin
                        mod3_next = mod3 + 2'd1;
                        div3_next = div3;
                    end
                end
            end
            default:
            begin
                push_cmd.op = lfss_pkg::OP_CLEAR;
                pos_next    = '0;
                div3_next   = '0;
                mod3_next   = 2'd0;
            end
        endcase
    end

    // Hold the frame position between transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            div3_reg <= '0;
            mod3_reg <= 2'd0;
        end
        else if (push)
        begin
            pos_reg  <= pos_next;
            div3_reg <= div3_next;
            mod3_reg <= mod3_next;
        end
    end

endmodule

FILE: hdl/lfss_queue.sv
`timescale 1ns / 1ps

module lfss_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lfss_pkg::cmd_t push_cmd,
    input  logic           pop,
    output lfss_pkg::cmd_t head,
    output logic           empty,
    output logic           full
);

    localparam int DEPTH = lfss_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lfss_pkg::cmd_t   entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head  = entries_reg[rd_ptr_reg];
    assign empty = count_reg == '0;
    assign full  = count_reg == CNT_W'(DEPTH);

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= DEPTH)
        else $error("command queue over capacity");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty command queue");

endmodule

FILE: hdl/lfss_back.sv
`timescale 1ns / 1ps

module lfss_back #(
    parameter int MAX_GROUPS = lfss_pkg::MAX_GROUPS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  lfss_pkg::cfg_t cfg,
    input  logic           empty,
    input  lfss_pkg::cmd_t head,
    output logic           pop,
    output logic           done,
    output logic [7:0]     out_data,
    output logic           end_of_frame,
    output logic           bad_index
);

    localparam int STORE_DEPTH = MAX_GROUPS * lfss_pkg::PIXELS_PER_GROUP;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FIRST  = 2'd1;
    localparam logic [1:0] ST_SECOND = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [STORE_DEPTH-1:0] valid_reg, valid_next;
    logic                   hit_reg, hit_next;
    lfss_pkg::cmd_t         cmd_reg, cmd_next;
    logic [15:0]            level_a_reg, level_a_next;
    logic [15:0]            level_b_reg, level_b_next;
    logic                   done_reg;
    logic [7:0]             data_reg;
    logic                   eof_reg;
    logic                   bad_reg;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [7:0]             ram_rdata;
    logic [7:0]             rd_byte;
    logic                   emit;
    logic [7:0]             emit_data;
    logic                   emit_eof;
    logic                   emit_bad;

    // Brightness curve: square, or shift up by one byte
    function automatic logic [15:0] curve(input logic [7:0] v, input logic shift_mode);
        return shift_mode ? {v, 8'h00} : ({8'h00, v} * {8'h00, v});
    endfunction

    lfss_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head.addr_a[ADDR_W-1:0]),
        .wdata (head.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Entries never written since reset or clear read as zero
    assign rd_byte = hit_reg ? ram_rdata : 8'h00;

    // Sequence one command at a time
    always_comb
    begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        hit_next     = hit_reg;
        cmd_next     = cmd_reg;
        level_a_next = level_a_reg;
        level_b_next = level_b_reg;
        pop          = 1'b0;
        ram_we       = 1'b0;
        ram_raddr    = cmd_reg.addr_b[ADDR_W-1:0];
        emit         = 1'b0;
        emit_data    = 8'h00;
        emit_eof     = 1'b0;
        emit_bad     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = head.addr_a[ADDR_W-1:0];
                if (!empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    hit_next = valid_reg[head.addr_a[ADDR_W-1:0]];
                    case (head.op)
                        lfss_pkg::OP_WRITE:
                        begin
                            ram_we = 1'b1;
                            valid_next[head.addr_a[ADDR_W-1:0]] = 1'b1;
                            emit = 1'b1;
                        end
                        lfss_pkg::OP_CLEAR:
                        begin
                            valid_next = '0;
                            emit       = 1'b1;
                        end
                        lfss_pkg::OP_READ, lfss_pkg::OP_BYTE:
                        begin
                            state_next = ST_FIRST;
                        end
                        lfss_pkg::OP_REPLY:
                        begin
                            emit     = 1'b1;
                            emit_bad = head.bad;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_FIRST:
            begin
                if (cmd_reg.op == lfss_pkg::OP_READ)
                begin
                    emit       = 1'b1;
                    emit_data  = rd_byte;
                    state_next = ST_IDLE;
                end
                else
                begin
                    level_a_next = curve(rd_byte, cfg.curve_mode);
                    if (cmd_reg.need_b)
                    begin
                        hit_next   = valid_reg[cmd_reg.addr_b[ADDR_W-1:0]];
                        state_next = ST_SECOND;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SECOND:
            begin
                level_b_next = curve(rd_byte, cfg.curve_mode);
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                emit       = 1'b1;
                emit_eof   = cmd_reg.eof;
                state_next = ST_IDLE;
                case (cmd_reg.byte_sel)
                    lfss_pkg::SEL_HI, lfss_pkg::SEL_P0: emit_data = level_a_reg[15:8];
                    lfss_pkg::SEL_LO: emit_data = level_a_reg[7:0];
                    lfss_pkg::SEL_P1: emit_data = {level_a_reg[7:4], level_b_reg[15:12]};
                    lfss_pkg::SEL_P2: emit_data = level_a_reg[11:4];
                    default:          emit_data = 8'h00;
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            hit_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
            done_reg  <= emit;
        end
    end

    // Hold command, levels and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        level_a_reg <= level_a_next;
        level_b_reg <= level_b_next;
        if (emit)
        begin
            data_reg <= emit_data;
            eof_reg  <= emit_eof;
            bad_reg  <= emit_bad;
        end
    end

    assign done         = done_reg;
    assign out_data     = data_reg;
    assign end_of_frame = eof_reg;
    assign bad_index    = bad_reg;

    a_second_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SECOND |-> $past(state_reg) == ST_FIRST && cmd_reg.need_b)
        else $error("second read without a packed byte");

    a_emit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |=> done_reg && !bad_reg)
        else $error("frame byte not delivered");

    a_eof_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && eof_reg |-> $past(state_reg) == ST_EMIT)
        else $error("end of frame outside a frame byte");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && bad_reg |-> data_reg == 8'h00)
        else $error("bad index result carries data");

endmodule

FILE: hdl/led_frame_store_serializer_core.sv
// LED frame store and serializer for chained grayscale driver chips.
// Command channel: an item (kind, pixel_index, pixel_value) transfers at a
// rising edge with start high and busy low. Kinds: write pixel, read pixel,
// next frame byte, clear store. Every item yields exactly one result.
// Result channel: done is high for one cycle with out_data, end_of_frame and
// bad_index; the receiver takes it at the edge ending that cycle and cannot
// stall it. busy rises only while the two-entry command queue is full.
// The back end answers a write, clear or bad index from its idle state as it
// takes the command from the queue; a read adds the registered store read; a
// frame byte also registers its level before an emit state; the middle byte
// of a packed 12-bit pair adds a second store read. done is registered. The
// back end, with its single store read port, ends each command before the next.
// Configuration: cfg_we writes cfg_data into register cfg_index (driver type,
// group count, chain remap, curve mode); write only while idle.
// Reset: registers take their reset values, the store reads as all zero
// through per-entry valid bits, which clear also resets, and the frame
// restarts at its first byte.
`timescale 1ns / 1ps

module led_frame_store_serializer_core #(
    parameter int MAX_GROUPS = lfss_pkg::MAX_GROUPS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] kind,
    input  logic [6:0] pixel_index,
    input  logic [7:0] pixel_value,
    output logic       done,
    output logic [7:0] out_data,
    output logic       end_of_frame,
    output logic       bad_index,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [1:0] cfg_data
);

    lfss_pkg::cfg_t cfg_reg;
    logic           push;
    lfss_pkg::cmd_t push_cmd;
    lfss_pkg::cmd_t head;
    logic           pop;
    logic           empty;
    logic           full;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.driver_type <= 1'b0;
            cfg_reg.group_count <= 2'd1;
            cfg_reg.chain_remap <= 1'b1;
            cfg_reg.curve_mode  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lfss_pkg::REG_DRIVER_TYPE: cfg_reg.driver_type <= cfg_data[0];
                lfss_pkg::REG_GROUP_COUNT: cfg_reg.group_count <= cfg_data;
                lfss_pkg::REG_CHAIN_REMAP: cfg_reg.chain_remap <= cfg_data[0];
                lfss_pkg::REG_CURVE_MODE:  cfg_reg.curve_mode  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign busy = full;

    lfss_front #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .start       (start),
        .full        (full),
        .kind        (kind),
        .pixel_index (pixel_index),
        .pixel_value (pixel_value),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    lfss_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    lfss_back #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .done         (done),
        .out_data     (out_data),
        .end_of_frame (end_of_frame),
        .bad_index    (bad_index)
    );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

localparam int LED_STORE_DEPTH = lfss_pkg::MAX_GROUPS_DEF * lfss_pkg::PIXELS_PER_GROUP;

typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       bad;
} led_reply_t;

// Shadow of the frame store: tracks store contents, frame position and
// register settings, and predicts the reply of every transfer in order.
class led_store_scoreboard;
    logic [7:0] bright[LED_STORE_DEPTH];
    logic [7:0] send_pos;
    logic       drv_12bit;
    logic [1:0] grp_cnt;
    logic       remap_en;
    logic       curve_shift;
    led_reply_t replies_q[$];
    int         errors;

    function new();
        foreach (bright[i])
            bright[i] = '0;
        send_pos    = '0;
        drv_12bit   = 1'b0;
        grp_cnt     = 2'd1;
        remap_en    = 1'b1;
        curve_shift = 1'b0;
        errors      = 0;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [1:0] data);
        case (idx)
            lfss_pkg::REG_DRIVER_TYPE: drv_12bit   = data[0];
            lfss_pkg::REG_GROUP_COUNT: grp_cnt     = data;
            lfss_pkg::REG_CHAIN_REMAP: remap_en    = data[0];
            lfss_pkg::REG_CURVE_MODE:  curve_shift = data[0];
            default: ;
        endcase
    endfunction

    // Saturate the group count to 1..MAX_GROUPS
    function int unsigned groups();
        int unsigned g;
        g = grp_cnt;
        if (g < 1)
            g = 1;
        if (g > lfss_pkg::MAX_GROUPS_DEF)
            g = lfss_pkg::MAX_GROUPS_DEF;
        return g;
    endfunction

    function int unsigned pixel_count();
        return groups() * lfss_pkg::PIXELS_PER_GROUP;
    endfunction

    function int unsigned frame_len();
        return drv_12bit ? (pixel_count() / 2) * 3 : pixel_count() * 2;
    endfunction

    function int pending();
        return replies_q.size();
    endfunction

    // Logical to physical pixel: lower half interleaves chips, upper half folds back
    function int unsigned to_phys(input int unsigned idx, input int unsigned g);
        int unsigned seg;
        seg = idx / lfss_pkg::CHIP_STEP;
        if (!remap_en)
            return idx;
        if (idx < g * lfss_pkg::PIXELS_PER_GROUP / 2)
            return idx + lfss_pkg::CHIP_STEP * seg;
        return (2 * g - 1 - seg) * 2 * lfss_pkg::CHIP_STEP + lfss_pkg::CHIP_STEP
               + idx % lfss_pkg::CHIP_STEP;
    endfunction

    // 16-bit drive level after the brightness curve
    function logic [15:0] level_of(input int unsigned phys);
        logic [7:0] v;
        v = (phys < LED_STORE_DEPTH) ? bright[phys] : 8'd0;
        return curve_shift ? {v, 8'h00} : 16'(v) * 16'(v);
    endfunction

    function void apply_item(input logic [1:0] kd, input logic [6:0] idx, input logic [7:0] val);
        led_reply_t  r;
        int unsigned g;
        int unsigned pcount;
        int unsigned phys;
        int unsigned flen;
        int unsigned pos;
        int unsigned t;
        logic [15:0] lv;
        logic [11:0] a;
        logic [11:0] b;
        r      = '0;
        g      = groups();
        pcount = pixel_count();
        case (kd)
            lfss_pkg::KIND_WRITE, lfss_pkg::KIND_READ:
            begin
                // drop out-of-range indexes, frame position untouched
                if (idx >= pcount)
                begin
                    r.bad = 1'b1;
                end
                else
                begin
                    phys = to_phys(idx, g);
                    if (phys < LED_STORE_DEPTH)
                    begin
                        if (kd == lfss_pkg::KIND_WRITE)
                        begin
                            bright[phys] = val;
                            send_pos     = '0;
                        end
                        else
                        begin
                            r.data = bright[phys];
                        end
                    end
                end
            end
            lfss_pkg::KIND_CLEAR:
            begin
                foreach (bright[i])
                    bright[i] = '0;
                send_pos = '0;
            end
            default:
            begin
                flen = frame_len();
                pos  = send_pos;
                // restart a position left past the end by a size change
                if (pos >= flen)
                    pos = 0;
                if (!drv_12bit)
                begin
                    lv     = level_of(pcount - 1 - pos / 2);
                    r.data = (pos % 2 == 1) ? lv[7:0] : lv[15:8];
                end
                else
                begin
                    // pack two 12-bit levels into three bytes
                    t  = pos / 3;
                    lv = level_of(pcount - 1 - 2 * t);
                    a  = lv[15:4];
                    lv = level_of(pcount - 2 - 2 * t);
                    b  = lv[15:4];
                    case (pos % 3)
                        0:       r.data = a[11:4];
                        1:       r.data = {a[3:0], b[11:8]};
                        default: r.data = b[7:0];
                    endcase
                end
                if (pos + 1 >= flen)
                begin
                    r.eof    = 1'b1;
                    send_pos = '0;
                end
                else
                begin
                    send_pos = 8'(pos + 1);
                end
            end
        endcase
        replies_q.push_back(r);
    endfunction

    function void cmp_field(input string name, input int unsigned exp, input int unsigned act);
        if (exp != act)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp, act);
            errors++;
        end
    endfunction

    function void check_reply(input logic [7:0] data, input logic eof, input logic bad);
        led_reply_t r;
        if (replies_q.size() == 0)
        begin
            $display("%0t: unexpected reply: out_data %0h end_of_frame %0b bad_index %0b",
                     $time, data, eof, bad);
            errors++;
            return;
        end
        r = replies_q.pop_front();
        cmp_field("out_data", r.data, data);
        cmp_field("end_of_frame", r.eof, eof);
        cmp_field("bad_index", r.bad, bad);
    endfunction
endclass

module tb_top;

    localparam int CYCLE_LIMIT = 100000;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       start       = 1'b0;
    logic       busy;
    logic [1:0] kind        = lfss_pkg::KIND_WRITE;
    logic [6:0] pixel_index = '0;
    logic [7:0] pixel_value = '0;
    logic       done;
    logic [7:0] out_data;
    logic       end_of_frame;
    logic       bad_index;
    logic       cfg_we      = 1'b0;
    logic [1:0] cfg_index   = lfss_pkg::REG_DRIVER_TYPE;
    logic [1:0] cfg_data    = '0;

    led_store_scoreboard store_sb;
    bit                  steady      = 1'b0;
    int                  cycle_count = 0;

    led_frame_store_serializer_core i_dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Take every reply in the cycle its strobe is high
    always @(posedge clk)
    begin
        if (rst_n && done)
            store_sb.check_reply(out_data, end_of_frame, bad_index);
    end

    function automatic logic [6:0] any_index();
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic logic [6:0] good_index();
        return 7'($urandom_range(0, store_sb.pixel_count() - 1));
    endfunction

    function automatic logic [6:0] out_of_range();
        return 7'($urandom_range(store_sb.pixel_count(), 127));
    endfunction

    function automatic logic [7:0] any_value();
        return 8'($urandom());
    endfunction

    function automatic logic [1:0] write_or_read();
        return ($urandom_range(0, 1) != 0) ? lfss_pkg::KIND_READ : lfss_pkg::KIND_WRITE;
    endfunction

    task automatic issue(input logic [1:0] k, input logic [6:0] idx, input logic [7:0] val);
        // idle now and then so gaps land on every stage of the back end
        if (!steady && $urandom_range(0, 99) < 10)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start       <= 1'b1;
        kind        <= k;
        pixel_index <= idx;
        pixel_value <= val;
        // hold the item until the transfer
        do
        begin
            @(posedge clk);
        end
        while (busy);
        store_sb.apply_item(k, idx, val);
    endtask

    // Drain all replies, then let the back end run dry
    task automatic settle();
        start <= 1'b0;
        while (store_sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        store_sb.write_reg(idx, data);
    endtask

    // Unused upper data bit of the 1-bit registers is randomized
    task automatic set_config(input logic drv, input logic [1:0] grp, input logic rmp,
                              input logic crv);
        settle();
        write_reg(lfss_pkg::REG_DRIVER_TYPE, {1'($urandom_range(0, 1)), drv});
        write_reg(lfss_pkg::REG_GROUP_COUNT, grp);
        write_reg(lfss_pkg::REG_CHAIN_REMAP, {1'($urandom_range(0, 1)), rmp});
        write_reg(lfss_pkg::REG_CURVE_MODE, {1'($urandom_range(0, 1)), crv});
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic drv, input logic [1:0] grp, input logic rmp,
                             input logic crv, input bit quiet);
        int unsigned sel;
        int unsigned left;
        int unsigned flen;
        set_config(drv, grp, rmp, crv);
        steady = quiet;
        // byte requests first: catch a position left stale by the size change
        repeat (3) issue(lfss_pkg::KIND_BYTE, any_index(), any_value());
        // random mix of every kind
        repeat (12)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
                issue(lfss_pkg::KIND_WRITE, good_index(), any_value());
            else if (sel < 50)
                issue(lfss_pkg::KIND_READ, good_index(), any_value());
            else if (sel < 75)
                issue(lfss_pkg::KIND_BYTE, any_index(), any_value());
            else if (sel < 80)
                issue(lfss_pkg::KIND_CLEAR, any_index(), any_value());
            else
                issue(write_or_read(), out_of_range(), any_value());
        end
        // fill some pixels, which also restarts the frame
        repeat (8) issue(lfss_pkg::KIND_WRITE, good_index(), any_value());
        // one whole frame and part of the next, reads and dropped items mixed in
        flen = store_sb.frame_len();
        left = flen + $urandom_range(flen * 3 / 8, flen * 5 / 8);
        while (left > 0)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 85)
            begin
                issue(lfss_pkg::KIND_BYTE, any_index(), any_value());
                left--;
            end
            else if (sel < 95)
            begin
                issue(lfss_pkg::KIND_READ, good_index(), any_value());
            end
            else
            begin
                issue(write_or_read(), out_of_range(), any_value());
            end
        end
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** led_frame_store_serializer_core: FAILED **");
        $finish;
    end

    initial
    begin
        store_sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: value extremes, chip boundaries, dropped indexes, clear
        issue(lfss_pkg::KIND_WRITE, 7'd0, 8'hFF);
        issue(lfss_pkg::KIND_WRITE, 7'd47, 8'h01);
        issue(lfss_pkg::KIND_WRITE, 7'd23, 8'h80);
        issue(lfss_pkg::KIND_WRITE, 7'd24, 8'h7F);
        issue(lfss_pkg::KIND_WRITE, 7'd48, 8'h55);
        issue(lfss_pkg::KIND_WRITE, 7'd127, 8'hAA);
        issue(lfss_pkg::KIND_READ, 7'd0, 8'h00);
        issue(lfss_pkg::KIND_READ, 7'd47, 8'hFF);
        issue(lfss_pkg::KIND_READ, 7'd23, 8'h00);
        issue(lfss_pkg::KIND_READ, 7'd24, 8'h00);
        issue(lfss_pkg::KIND_READ, 7'd48, 8'h00);
        issue(lfss_pkg::KIND_READ, 7'd127, 8'hFF);
        repeat (4) issue(lfss_pkg::KIND_BYTE, 7'd0, 8'h00);
        issue(lfss_pkg::KIND_CLEAR, 7'd127, 8'hFF);
        issue(lfss_pkg::KIND_READ, 7'd0, 8'h00);
        issue(lfss_pkg::KIND_BYTE, 7'd127, 8'hFF);
        issue(lfss_pkg::KIND_WRITE, 7'd47, 8'hFF);
        repeat (2) issue(lfss_pkg::KIND_BYTE, 7'd0, 8'h00);

        // Random phases over several settings; the second runs with no idling
        run_phase(1'b1, 2'd2, 1'b1, 1'b0, 1'b0);
        run_phase(1'b0, 2'd3, 1'b1, 1'b1, 1'b1);
        run_phase(1'b1, 2'd0, 1'b0, 1'b1, 1'b0);

        settle();
        if (store_sb.errors == 0 && store_sb.pending() == 0)
            $display("** led_frame_store_serializer_core: PASSED **");
        else
            $display("** led_frame_store_serializer_core: FAILED **");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/lfss_pkg.sv
hdl/lfss_ram.sv
hdl/lfss_front.sv
hdl/lfss_queue.sv
hdl/lfss_back.sv
hdl/led_frame_store_serializer_core.sv
sim/tb_top.sv
